[rtl/core/modexp_pkg.sv]
// Shared definitions for the modular exponentiation block: widths, microcode
// word layout, operation and condition codes, and the control store itself.
// No dependencies.
package modexp_pkg;

    localparam int MOD_WIDTH  = 31;
    localparam int DATA_WIDTH = 31;
    localparam int EXP_WIDTH  = 63;
    localparam int CNT_WIDTH  = $clog2(EXP_WIDTH + 1);
    localparam int PC_WIDTH   = 5;

    typedef logic [3:0]          op_t;
    typedef logic [3:0]          cond_t;
    typedef logic [PC_WIDTH-1:0] pc_t;

    // Datapath operations.
    localparam op_t OP_NOP   = 4'd0;
    localparam op_t OP_LOAD  = 4'd1;
    localparam op_t OP_RED_E = 4'd2;
    localparam op_t OP_LD_B  = 4'd3;
    localparam op_t OP_RED_B = 4'd4;
    localparam op_t OP_INIT  = 4'd5;
    localparam op_t OP_LD_MA = 4'd6;
    localparam op_t OP_MUL   = 4'd7;
    localparam op_t OP_WB_A  = 4'd8;
    localparam op_t OP_SHR_E = 4'd9;
    localparam op_t OP_LD_MS = 4'd10;
    localparam op_t OP_WB_S  = 4'd11;
    localparam op_t OP_ZERO  = 4'd12;
    localparam op_t OP_OUT   = 4'd13;

    // Jump conditions. The jump is taken when the condition holds.
    localparam cond_t COND_NEVER     = 4'd0;
    localparam cond_t COND_ALWAYS    = 4'd1;
    localparam cond_t COND_NOT_START = 4'd2;
    localparam cond_t COND_MOD_SMALL = 4'd3;
    localparam cond_t COND_CNT_MORE  = 4'd4;
    localparam cond_t COND_E_ZERO    = 4'd5;
    localparam cond_t COND_BIT_CLR   = 4'd6;
    localparam cond_t COND_E_LAST    = 4'd7;
    localparam cond_t COND_OUT_BUSY  = 4'd8;

    // Program step addresses.
    localparam pc_t P_IDLE  = 5'd0;
    localparam pc_t P_CHECK = 5'd1;
    localparam pc_t P_RED_E = 5'd2;
    localparam pc_t P_LD_B  = 5'd3;
    localparam pc_t P_RED_B = 5'd4;
    localparam pc_t P_INIT  = 5'd5;
    localparam pc_t P_TEST  = 5'd6;
    localparam pc_t P_LD_MA = 5'd7;
    localparam pc_t P_MUL_A = 5'd8;
    localparam pc_t P_WB_A  = 5'd9;
    localparam pc_t P_SHIFT = 5'd10;
    localparam pc_t P_LD_MS = 5'd11;
    localparam pc_t P_MUL_S = 5'd12;
    localparam pc_t P_WB_S  = 5'd13;
    localparam pc_t P_ZERO  = 5'd14;
    localparam pc_t P_OUT   = 5'd15;
    localparam pc_t P_RET   = 5'd16;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        logic start;
        logic mod_small;
        logic cnt_more;
        logic e_zero;
        logic bit_clr;
        logic e_last;
        logic out_busy;
    } status_t;

    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t w;
        case (pc)
            P_IDLE:  w = '{OP_LOAD,  COND_NOT_START, P_IDLE};
            P_CHECK: w = '{OP_NOP,   COND_MOD_SMALL, P_ZERO};
            P_RED_E: w = '{OP_RED_E, COND_CNT_MORE,  P_RED_E};
            P_LD_B:  w = '{OP_LD_B,  COND_NEVER,     P_IDLE};
            P_RED_B: w = '{OP_RED_B, COND_CNT_MORE,  P_RED_B};
            P_INIT:  w = '{OP_INIT,  COND_E_ZERO,    P_OUT};
            P_TEST:  w = '{OP_NOP,   COND_BIT_CLR,   P_SHIFT};
            P_LD_MA: w = '{OP_LD_MA, COND_NEVER,     P_IDLE};
            P_MUL_A: w = '{OP_MUL,   COND_CNT_MORE,  P_MUL_A};
            P_WB_A:  w = '{OP_WB_A,  COND_NEVER,     P_IDLE};
            P_SHIFT: w = '{OP_SHR_E, COND_E_LAST,    P_OUT};
            P_LD_MS: w = '{OP_LD_MS, COND_NEVER,     P_IDLE};
            P_MUL_S: w = '{OP_MUL,   COND_CNT_MORE,  P_MUL_S};
            P_WB_S:  w = '{OP_WB_S,  COND_ALWAYS,    P_TEST};
            P_ZERO:  w = '{OP_ZERO,  COND_ALWAYS,    P_OUT};
            P_OUT:   w = '{OP_OUT,   COND_OUT_BUSY,  P_OUT};
            P_RET:   w = '{OP_NOP,   COND_ALWAYS,    P_IDLE};
            default: w = '{OP_NOP,   COND_ALWAYS,    P_IDLE};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/modexp_seq.sv]
// Microcode sequencer for the modular exponentiation block: step counter,
// control store lookup and conditional jumps. Depends on modexp_pkg.
module modexp_seq
    import modexp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output uword_t  uword
);

    pc_t  pc_reg;
    pc_t  pc_next;
    logic take;

    assign uword = ucode_rom(pc_reg);

    always_comb begin
        case (uword.cond)
            COND_NEVER:     take = 1'b0;
            COND_ALWAYS:    take = 1'b1;
            COND_NOT_START: take = !status.start;
            COND_MOD_SMALL: take = status.mod_small;
            COND_CNT_MORE:  take = status.cnt_more;
            COND_E_ZERO:    take = status.e_zero;
            COND_BIT_CLR:   take = status.bit_clr;
            COND_E_LAST:    take = status.e_last;
            COND_OUT_BUSY:  take = status.out_busy;
            default:        take = 1'b1;
        endcase
        pc_next = take ? uword.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= P_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

[rtl/core/modular_exponentiation.sv]
// Modular exponentiation engine: top level with the datapath and output
// register, driven by the microcode sequencer. Depends on modexp_pkg and
// modexp_seq.
//
// Each input transaction carries a base, an exponent and a modulus; the block
// returns base to the power (exponent mod (modulus - 1)), modulo the modulus,
// as one output transaction. A modulus below two gives 0, and an exponent
// that reduces to zero gives 1. The work runs one item at a time under a small
// microprogram over a single shared datapath: a restoring remainder step
// reduces the exponent one bit per cycle and then the base, and every modular
// multiply or squaring is a bit-serial shift-add-reduce. A modulus below two
// skips the reductions. The block takes a new transaction as soon as the
// sequencer is back at its idle step; a finished result sits in the output
// register until it is taken, so the next item can already be accepted and
// computed. No state carries over from one item to the next.
module modular_exponentiation
    import modexp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_WIDTH-1:0] s_base,
    input  logic [EXP_WIDTH-1:0]  s_exponent,
    input  logic [DATA_WIDTH-1:0] s_modulus,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-1:0] m_power_residue
);

    // Operand registers. The exponent register first shifts out its bits into
    // the remainder step and is then reloaded with the reduced exponent.
    logic [MOD_WIDTH-1:0] b_reg;
    logic [MOD_WIDTH-1:0] m_reg;
    logic [EXP_WIDTH-1:0] e_reg;
    logic [MOD_WIDTH-1:0] rem_reg;
    logic [MOD_WIDTH-1:0] acc_reg;
    logic [MOD_WIDTH-1:0] sq_reg;
    logic [MOD_WIDTH-1:0] x_reg;
    logic [MOD_WIDTH-1:0] y_reg;
    logic [MOD_WIDTH-1:0] p_reg;
    logic [CNT_WIDTH-1:0] cnt_reg;

    logic [DATA_WIDTH-1:0] out_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    uword_t  uword;
    status_t status;
    logic    accept;
    logic    out_load;

    // Restoring remainder step, shared by the exponent and base reductions.
    logic [MOD_WIDTH-1:0] red_div;
    logic                 red_bit;
    logic [MOD_WIDTH:0]   red_trial;
    logic [MOD_WIDTH:0]   red_diff;
    logic [MOD_WIDTH-1:0] rem_next;

    // Bit-serial modular multiply step: p = 2p + (x bit ? y : 0), reduced.
    logic [MOD_WIDTH+1:0] mul_sum;
    logic [MOD_WIDTH+1:0] mul_m1;
    logic [MOD_WIDTH+1:0] mul_m2;
    logic [MOD_WIDTH-1:0] p_next;

    modexp_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .uword   (uword)
    );

    assign s_ready = (uword.op == OP_LOAD);
    assign accept  = s_valid && s_ready;

    always_comb begin
        status.start     = s_valid;
        status.mod_small = (m_reg < MOD_WIDTH'(2));
        status.cnt_more  = (cnt_reg != CNT_WIDTH'(1));
        status.e_zero    = (e_reg == '0);
        status.bit_clr   = !e_reg[0];
        status.e_last    = (e_reg[EXP_WIDTH-1:1] == '0);
        status.out_busy  = out_valid_reg && !m_ready;
    end

    assign out_load = (uword.op == OP_OUT) && !status.out_busy;

    always_comb begin
        if (uword.op == OP_RED_E) begin
            red_div = m_reg - MOD_WIDTH'(1);
            red_bit = e_reg[EXP_WIDTH-1];
        end else begin
            red_div = m_reg;
            red_bit = b_reg[MOD_WIDTH-1];
        end
        red_trial = {rem_reg, red_bit};
        red_diff  = red_trial - {1'b0, red_div};
        if (red_trial >= {1'b0, red_div}) begin
            rem_next = red_diff[MOD_WIDTH-1:0];
        end else begin
            rem_next = red_trial[MOD_WIDTH-1:0];
        end
    end

    always_comb begin
        mul_m1  = (MOD_WIDTH+2)'(m_reg);
        mul_m2  = (MOD_WIDTH+2)'({m_reg, 1'b0});
        mul_sum = (MOD_WIDTH+2)'({p_reg, 1'b0})
                + (x_reg[MOD_WIDTH-1] ? (MOD_WIDTH+2)'(y_reg) : '0);
        if (mul_sum >= mul_m2) begin
            p_next = MOD_WIDTH'(mul_sum - mul_m2);
        end else if (mul_sum >= mul_m1) begin
            p_next = MOD_WIDTH'(mul_sum - mul_m1);
        end else begin
            p_next = mul_sum[MOD_WIDTH-1:0];
        end
    end

    // Datapath registers, steered by the current control word.
    always_ff @(posedge aclk) begin
        case (uword.op)
            OP_LOAD: begin
                if (accept) begin
                    b_reg   <= s_base[MOD_WIDTH-1:0];
                    m_reg   <= s_modulus[MOD_WIDTH-1:0];
                    e_reg   <= s_exponent;
                    rem_reg <= '0;
                    cnt_reg <= CNT_WIDTH'(EXP_WIDTH);
                end
            end
            OP_RED_E: begin
                rem_reg <= rem_next;
                e_reg   <= {e_reg[EXP_WIDTH-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end
            OP_LD_B: begin
                e_reg   <= EXP_WIDTH'(rem_reg);
                rem_reg <= '0;
                cnt_reg <= CNT_WIDTH'(MOD_WIDTH);
            end
            OP_RED_B: begin
                rem_reg <= rem_next;
                b_reg   <= {b_reg[MOD_WIDTH-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end
            OP_INIT: begin
                sq_reg  <= rem_reg;
                acc_reg <= MOD_WIDTH'(1);
            end
            OP_LD_MA: begin
                x_reg   <= acc_reg;
                y_reg   <= sq_reg;
                p_reg   <= '0;
                cnt_reg <= CNT_WIDTH'(MOD_WIDTH);
            end
            OP_LD_MS: begin
                x_reg   <= sq_reg;
                y_reg   <= sq_reg;
                p_reg   <= '0;
                cnt_reg <= CNT_WIDTH'(MOD_WIDTH);
            end
            OP_MUL: begin
                p_reg   <= p_next;
                x_reg   <= {x_reg[MOD_WIDTH-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end
            OP_WB_A: begin
                acc_reg <= p_reg;
            end
            OP_WB_S: begin
                sq_reg <= p_reg;
            end
            OP_SHR_E: begin
                e_reg <= {1'b0, e_reg[EXP_WIDTH-1:1]};
            end
            OP_ZERO: begin
                acc_reg <= '0;
            end
            default: begin
            end
        endcase
    end

    // Output register: loaded when the program reaches its output step and
    // the previous result has been taken or is being taken now.
    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= DATA_WIDTH'(acc_reg);
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_power_residue = out_reg;

`ifndef SYNTHESIS
    // The multiply accumulator stays a proper residue throughout a multiply.
    a_mul_partial_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        uword.op == OP_MUL |-> p_reg < m_reg)
        else $error("multiply partial sum not reduced below the modulus");

    // Both multiply operands are residues when a multiply is started.
    a_operands_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (uword.op == OP_LD_MA || uword.op == OP_LD_MS)
        |-> (acc_reg < m_reg && sq_reg < m_reg))
        else $error("multiply operand not reduced below the modulus");

    // The reduced exponent is below the modulus minus one.
    a_exp_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        uword.op == OP_LD_B |-> rem_reg < m_reg - MOD_WIDTH'(1))
        else $error("exponent remainder out of range");

    // A result is only written for a valid modulus when it is a residue.
    a_result_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && !status.mod_small |-> acc_reg < m_reg)
        else $error("result not reduced below the modulus");

    // A waiting result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> $stable(out_reg))
        else $error("pending result overwritten");
`endif

endmodule

[test/tb_modular_exponentiation.sv]
// Self-checking testbench for modular_exponentiation: directed and random operand sets,
// random idling on both channels, and a bit-true predictor of each residue.
// Depends on modexp_pkg and the modular_exponentiation RTL.
`timescale 1ns / 100ps

module tb_modular_exponentiation;
    import modexp_pkg::*;

    // One input transaction: base, exponent and modulus as the block sees them.
    typedef struct {
        logic [DATA_WIDTH-1:0] base;
        logic [EXP_WIDTH-1:0]  exponent;
        logic [DATA_WIDTH-1:0] modulus;
    } operand_set_t;

    localparam logic [DATA_WIDTH-1:0] MODULUS_MAX  = {DATA_WIDTH{1'b1}};
    localparam logic [EXP_WIDTH-1:0]  EXPONENT_MAX = {EXP_WIDTH{1'b1}};
    localparam int RANDOM_SETS    = 1230;
    localparam int DRAIN_CYCLES   = 300;
    // The limit covers, with a wide margin, the slowest item, which passes with no
    // transaction on either side, plus a receiver stall or a sender pause on top.
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int REPORT_LIMIT   = 10;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [DATA_WIDTH-1:0] s_base          = '0;
    logic [EXP_WIDTH-1:0]  s_exponent      = '0;
    logic [DATA_WIDTH-1:0] s_modulus       = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [DATA_WIDTH-1:0] m_power_residue;

    operand_set_t          pending_operands[$];
    logic [DATA_WIDTH-1:0] expected_residues[$];

    // The monitor sets these flags at a rising edge. The driver and the receiver
    // read them at the next falling edge.
    logic operands_taken = 1'b0;
    logic residue_taken  = 1'b0;

    int residue_failures = 0;
    int sets_accepted    = 0;
    int residues_checked = 0;
    int degenerate_sets  = 0;
    int wide_sets        = 0;
    int idle_cycles      = 0;

    int send_pause   = 0;
    bit send_steady  = 1'b0;
    int recv_stall   = 0;
    bit recv_steady  = 1'b0;

    modular_exponentiation u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_base          (s_base),
        .s_exponent      (s_exponent),
        .s_modulus       (s_modulus),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_power_residue (m_power_residue)
    );

    always #4 aclk = ~aclk;

    // Reduce the exponent modulo (modulus - 1), then square-and-multiply with
    // the base reduced modulo the modulus. A modulus below two gives zero.
    // All operands stay below 2^31, so every product fits in 64 bits.
    function automatic logic [DATA_WIDTH-1:0] predict_power_residue(input operand_set_t op);
        logic [63:0] mask;
        logic [63:0] b;
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] acc;
        logic [63:0] sq;
        mask = (64'd1 << MOD_WIDTH) - 64'd1;
        b    = 64'(op.base) & mask;
        e    = 64'(op.exponent);
        m    = 64'(op.modulus) & mask;
        if (m < 64'd2)
            return '0;
        e   = e % (m - 64'd1);
        acc = 64'd1;
        sq  = b % m;
        while (e != 64'd0) begin
            if (e[0])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            e  = e >> 1;
        end
        return acc[DATA_WIDTH-1:0];
    endfunction

    // Pauses are mostly short, a few are long. In a steady stretch there are none.
    function automatic int pause_length(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 40);
        return $urandom_range(100, 400);
    endfunction

    task automatic queue_operands(input logic [DATA_WIDTH-1:0] base,
                                  input logic [EXP_WIDTH-1:0] exponent,
                                  input logic [DATA_WIDTH-1:0] modulus);
        operand_set_t op;
        op.base     = base;
        op.exponent = exponent;
        op.modulus  = modulus;
        pending_operands = {pending_operands, op};
    endtask

    task automatic note_failure(input string what, input logic [DATA_WIDTH-1:0] want,
                                input logic [DATA_WIDTH-1:0] got);
        residue_failures++;
        if (residue_failures <= REPORT_LIMIT)
            $display("%0t: %s: expected residue %0d, got %0d", $realtime, what, want, got);
    endtask

    // Driver. The next operand set is loaded at the falling edge once the
    // previous one has been accepted and the pause drawn for it has run out.
    // The next value of s_valid is computed first and assigned only once,
    // so back-to-back transactions keep s_valid high without a glitch.
    always @(negedge aclk) begin
        operand_set_t op;
        logic         next_valid;
        if (aresetn) begin
            next_valid = s_valid && !operands_taken;
            if (!next_valid) begin
                if (send_pause > 0) begin
                    send_pause--;
                end else if (pending_operands.size() > 0) begin
                    op = pending_operands.pop_front();
                    s_base     <= op.base;
                    s_exponent <= op.exponent;
                    s_modulus  <= op.modulus;
                    next_valid = 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        send_steady = !send_steady;
                    send_pause = pause_length(send_steady);
                end
            end
            s_valid <= next_valid;
        end
    end

    // Receiver. A stall may start after each result or at any idle moment.
    // This lets ready drop both before and during the presentation of a result.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (residue_taken && $urandom_range(0, 15) == 0)
                recv_steady = !recv_steady;
            if (recv_stall == 0 && (residue_taken || $urandom_range(0, 31) == 0))
                recv_stall = pause_length(recv_steady);
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor. An accepted operand set is turned into its expected residue at once.
    // Each accepted result is compared with the oldest residue still waiting.
    always @(posedge aclk) begin
        operand_set_t          taken;
        logic [DATA_WIDTH-1:0] want;
        if (!aresetn) begin
            operands_taken <= 1'b0;
            residue_taken  <= 1'b0;
        end else begin
            operands_taken <= s_valid && s_ready;
            residue_taken  <= m_valid && m_ready;
            if (s_valid && s_ready) begin
                taken.base     = s_base;
                taken.exponent = s_exponent;
                taken.modulus  = s_modulus;
                expected_residues = {expected_residues, predict_power_residue(taken)};
                sets_accepted++;
                if (s_modulus < 2)
                    degenerate_sets++;
                if (s_modulus[DATA_WIDTH-1])
                    wide_sets++;
            end
            if (m_valid && m_ready) begin
                if (expected_residues.size() == 0) begin
                    note_failure("result with no transaction outstanding", '0, m_power_residue);
                end else begin
                    want = expected_residues.pop_front();
                    residues_checked++;
                    if (m_power_residue !== want)
                        note_failure("power_residue mismatch", want, m_power_residue);
                end
            end
        end
    end

    // Watchdog: a run that stops moving on both channels is a failure.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                         idle_cycles, expected_residues.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        logic [DATA_WIDTH-1:0] m;
        logic [DATA_WIDTH-1:0] b;
        logic [EXP_WIDTH-1:0]  e;
        logic [63:0]           wide;
        int                    pick;

        // Directed part: the edges of each field and every special case.
        queue_operands('0, '0, MODULUS_MAX);                  // exponent zero
        queue_operands(MODULUS_MAX, EXPONENT_MAX, MODULUS_MAX);
        queue_operands(31'd12345, 63'd678, '0);               // modulus zero
        queue_operands(MODULUS_MAX, EXPONENT_MAX, 31'd1);     // modulus one
        queue_operands(31'd3, 63'd12345, 31'd2);              // modulus two
        // Base a multiple of the modulus with an exponent that reduces to zero:
        // the residue is still one.
        queue_operands(31'd2000006, 63'(5 * 1000002), 31'd1000003);
        queue_operands(31'd2000006, 63'd7, 31'd1000003);      // base multiple, residue zero
        queue_operands(MODULUS_MAX, 63'd1000, 31'd97);        // base far above the modulus
        queue_operands(31'd123, 63'd999999, 31'd1000);        // composite modulus
        queue_operands(31'd77, 63'(3 * 1000002 + 1), 31'd1000003); // reduces to one
        queue_operands(31'd5, 63'd1000001, 31'd1000003);      // inverse by Fermat
        queue_operands(31'd2, 63'd1, 31'd3);
        queue_operands(31'd1, EXPONENT_MAX, MODULUS_MAX - 31'd1);
        queue_operands(MODULUS_MAX - 31'd1, 63'd1, MODULUS_MAX);
        queue_operands(31'd5, {1'b1, {(EXP_WIDTH-1){1'b0}}}, 31'd65537);
        queue_operands(31'h4000_0000, {2'b00, {(EXP_WIDTH-2){1'b1}}}, MODULUS_MAX - 31'd1);
        queue_operands('0, EXPONENT_MAX, MODULUS_MAX);
        // Largest reduced exponent with the widest modulus: the slowest item.
        queue_operands(31'd3, 63'(MODULUS_MAX - 31'd2), MODULUS_MAX);
        queue_operands(31'd254, 63'd3, 31'd255);
        queue_operands('0, 63'(MODULUS_MAX - 31'd1), MODULUS_MAX); // zero to a zero power

        // Random part. Most moduli are small so that the reduced exponents, and
        // with them the run, stay short. A share spans the full width.
        for (int i = 0; i < RANDOM_SETS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                m = 31'($urandom_range(2, 255));
            else if (pick < 85)
                m = 31'($urandom_range(256, 65535));
            else if (pick < 97)
                m = 31'($urandom_range(2, 32'h7fff_ffff));
            else
                m = 31'($urandom_range(0, 1));

            if ($urandom_range(0, 4) == 0)
                b = 31'(m * $urandom_range(0, 3));
            else
                b = 31'($urandom);

            // Mostly full-width exponents, some tiny ones, and some that land
            // exactly on a multiple of (modulus - 1), or one past it.
            pick = $urandom_range(0, 9);
            wide = {$urandom, $urandom};
            if (pick == 0)
                e = 63'($urandom_range(0, 40));
            else if (pick == 1 && m >= 2)
                e = 63'(64'(m - 31'd1) * $urandom_range(0, 1 << 20) + $urandom_range(0, 1));
            else
                e = wide[EXP_WIDTH-1:0];

            queue_operands(b, e, m);
        end

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for the stimulus to drain and for every residue to arrive. If the
        // block stops short, the watchdog ends the run, so no expectation can
        // remain when these loops finish.
        while (pending_operands.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_residues.size() != 0)
            @(posedge aclk);
        // Give a stray extra result the time to show up.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d operand sets and checked %0d residues.",
                 sets_accepted, residues_checked);
        $display("Of these, %0d had a modulus below two and %0d a full-width modulus;",
                 degenerate_sets, wide_sets);
        $display("%0d failures.", residue_failures);
        if (residue_failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
rtl/core/modexp_pkg.sv
rtl/core/modexp_seq.sv
rtl/core/modular_exponentiation.sv
test/tb_modular_exponentiation.sv
